// ===== hw/rtl/lzfw_pkg.sv =====
// Shared constants and controller/datapath handshake structs for the LZ77
// window decoder. No dependencies.
package lzfw_pkg;

	localparam int POS_W    = 40;
	localparam int LEN_W    = 7;
	localparam int BYTE_W   = 8;
	localparam int WINDOW   = 65536;
	localparam int MAX_COPY = 64;
	// WINDOW is a power of two: the ring index is the low bits of a position
	localparam int RING_AW  = $clog2(WINDOW);
	localparam int IN_W     = 48;

	localparam logic [POS_W-1:0] WINDOW_POS   = POS_W'(WINDOW);
	localparam logic [LEN_W-1:0] MAX_COPY_LEN = LEN_W'(MAX_COPY);

	typedef struct packed {
		logic load;       // capture the accepted factor
		logic check;      // evaluate the window test
		logic rd_en;      // read the ring at the copy source
		logic emit_lit;   // write and emit the literal byte
		logic emit_copy;  // write and emit the byte just read
		logic emit_err;   // emit the error result
	} lzfw_cmd_t;

	typedef struct packed {
		logic in_lit;     // incoming factor is a literal
		logic err;        // copy fails the window test
		logic last;       // current copy byte is the last of its run
		logic out_free;   // output register can take a result this cycle
	} lzfw_sts_t;

endpackage

// ===== hw/rtl/lzfw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/lzfw_ctrl.sv =====
// Sequencer for the LZ77 window decoder: one factor at a time, a read and a
// write state per copied byte. Depends on lzfw_pkg.
module lzfw_ctrl
	import lzfw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  lzfw_sts_t sts,
	output lzfw_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_LIT   = 6'b000100,
		ST_ERR   = 6'b001000,
		ST_READ  = 6'b010000,
		ST_WRITE = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.in_lit ? ST_LIT : ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_READ;
			end
			ST_READ: begin
				// error flag from the check is valid from here on
				if (sts.err) begin
					state_d = ST_ERR;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_WRITE;
				end
			end
			ST_LIT: begin
				if (sts.out_free) begin
					cmd.emit_lit = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (sts.out_free) begin
					cmd.emit_err = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_WRITE: begin
				if (sts.out_free) begin
					cmd.emit_copy = 1'b1;
					state_d       = sts.last ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_read_then_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> state_q == ST_WRITE)
		else $error("ring read not followed by write cycle");

endmodule

// ===== hw/rtl/lzfw_dp.sv =====
// Datapath of the LZ77 window decoder: factor registers, window check,
// history ring and output register. Depends on lzfw_pkg and lzfw_ram.
module lzfw_dp
	import lzfw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IN_W-1:0]   in_data,
	input  lzfw_cmd_t         cmd,
	output lzfw_sts_t         sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_last,
	output logic              out_err
);

	logic [POS_W-1:0]  src_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [POS_W-1:0]  pos_q;
	logic              err_q;
	logic [POS_W-1:0]  copy_dist;
	logic [LEN_W-1:0]  in_len;
	logic [BYTE_W-1:0] rd_data;
	logic [BYTE_W-1:0] wr_data;
	logic              wr_en;
	logic              emit;

	assign in_len    = in_data[POS_W +: LEN_W];
	assign copy_dist = pos_q - src_q;

	assign sts.in_lit   = (in_len == '0);
	assign sts.err      = err_q;
	assign sts.last     = (cnt_q == LEN_W'(1));
	assign sts.out_free = !out_valid || out_ready;

	assign wr_en   = cmd.emit_lit || cmd.emit_copy;
	assign wr_data = cmd.emit_lit ? src_q[BYTE_W-1:0] : rd_data;
	assign emit    = wr_en || cmd.emit_err;

	// factor registers; src_q doubles as the copy read pointer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q <= in_data[POS_W-1:0];
			cnt_q <= (in_len > MAX_COPY_LEN) ? MAX_COPY_LEN : in_len;
		end else if (cmd.emit_copy) begin
			src_q <= src_q + POS_W'(1);
			cnt_q <= cnt_q - LEN_W'(1);
		end
		if (cmd.check) begin
			err_q <= (src_q >= pos_q) || (copy_dist > WINDOW_POS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (wr_en) begin
			pos_q <= pos_q + POS_W'(1);
		end
	end

	lzfw_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (WINDOW)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pos_q[RING_AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (src_q[RING_AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte <= cmd.emit_err ? '0 : wr_data;
			out_last <= cmd.emit_err || cmd.emit_lit || sts.last;
			out_err  <= cmd.emit_err;
		end
	end

	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> sts.out_free)
		else $error("result emitted over an untaken result");

	a_pos_advance: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> pos_q == $past(pos_q) + POS_W'(1))
		else $error("output position did not advance on a ring write");

	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_err |-> out_last && out_byte == '0)
		else $error("error result not a single zero byte");

endmodule

// ===== hw/rtl/lz77_factor_window_decoder_unit.sv =====
// Top level of the LZ77 factor window decoder: controller plus datapath.
// Depends on lzfw_pkg, lzfw_ctrl, lzfw_dp (which holds lzfw_ram).
// Usage:
//   s_axis carries one factor per transaction: tdata[39:0] source_position,
//   tdata[46:40] copy_length, tdata[47] zero. A length of zero is a literal
//   whose byte sits in source_position[7:0].
//   m_axis carries one decoded byte per transaction: tdata[7:0] data_byte,
//   tlast marks the last byte of a factor, tuser flags a copy whose source is
//   not behind the output position or more than WINDOW bytes back (that factor
//   yields one zero byte with tlast and tuser set, and changes nothing).
// Sequence:
//   One factor is in flight at a time; s_axis_tready is high only while the
//   sequencer is idle. After acceptance a literal goes through ST_LIT to the
//   output register, an error result through ST_CHECK, ST_READ and ST_ERR,
//   the first byte of a copy through ST_CHECK, ST_READ and ST_WRITE. The next
//   factor is taken only back in ST_IDLE, after the last byte of a copy of L
//   bytes (L clamped to 64): each byte needs a read and a write state on the
//   history RAM, which keeps overlapping copies exact.
// Reset clears the sequencer, output position and output valid, not the RAM.
// Stall: a low m_axis_tready holds the result and the sequencer; none dropped.
module lz77_factor_window_decoder_unit
	import lzfw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// factor in
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_W-1:0]   s_axis_tdata,  // [39:0] source_position, [46:40] copy_length
	// bytes out
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [BYTE_W-1:0] m_axis_tdata,  // [7:0] data_byte
	output logic              m_axis_tlast,  // last_of_factor
	output logic              m_axis_tuser   // [0] out_of_window
);

	lzfw_cmd_t cmd;
	lzfw_sts_t sts;

	// sequencer: decide per cycle what the datapath does
	lzfw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: hold factor, run the window check, move bytes through the ring
	lzfw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_err   (m_axis_tuser)
	);

endmodule
